@@ hw/rtl/obot_pkg.sv @@
// shared constants of the oriented box overlap test
`timescale 1ns / 1ps
package obot_pkg;

    // command codes carried on the input tuser
    localparam logic CMD_STORE = 1'b0;
    localparam logic CMD_TEST  = 1'b1;

    // result tdata width: one overlap flag padded to a byte
    localparam int OUT_W = 8;

endpackage

@@ hw/rtl/oriented_box_overlap_test.sv @@
// oriented box overlap test by separating axes over one shared multiplier
// store transfer: no result, block stays ready
// test transfer: box axes and then cross axes are tested in turn, 15 axes at most;
// the first separating axis ends the run early
// all axes share one multiplier and accumulator; no transfer is taken until the result is out
// synchronous active-low reset zeroes control and the reference box, but sets the result flag
`timescale 1ns / 1ps
module oriented_box_overlap_test
    import obot_pkg::*;
#(
    parameter int COORD_WIDTH  = 24,
    parameter int AXIS_WIDTH   = 16,
    parameter int LENGTH_WIDTH = 20
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // center_x, center_y, center_z, axis_u, axis_v, axis_w, edge_lengths
    input  logic [((3*COORD_WIDTH+9*AXIS_WIDTH+3*LENGTH_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // cmd
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // overlap
    output logic [OUT_W-1:0]      m_axis_tdata
);

    localparam int CW   = COORD_WIDTH;
    localparam int AW_  = AXIS_WIDTH;
    localparam int LNW  = LENGTH_WIDTH;
    localparam int OFF_AX = 3*CW;
    localparam int OFF_LN = 3*CW + 9*AW_;
    localparam int DSW  = CW + 1;                 // centre difference
    localparam int SW   = 2*AW_ + 1;              // candidate axis component
    localparam int BW0  = (DSW > AW_) ? DSW : AW_;
    localparam int BW   = (BW0 > LNW + 1) ? BW0 : LNW + 1;
    localparam int PW   = SW + BW;                // product
    localparam int ACW  = PW + 2;                 // dot accumulator
    localparam int DW   = 3*AW_ + 3;              // shadow dot magnitude
    localparam int LW   = ACW + AW_ - 1;          // scaled centre side
    localparam int RW   = DW + LNW + 3;           // shadow sum
    localparam int XW   = (LW > RW) ? LW : RW;

    localparam logic [1:0] GRP_REF = 2'd0;
    localparam logic [1:0] GRP_TST = 2'd1;
    localparam logic [1:0] GRP_CRS = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SETUP, ST_CROSS, ST_DDOT, ST_LHS, ST_SHDOT, ST_SHLEN, ST_DONE
    } state_t;

    state_t state_reg;
    logic [1:0] grp_reg, ia_reg, jb_reg;
    logic [2:0] cnt_reg, k_reg;
    logic       ph_reg;
    logic       result_reg;
    logic       m_valid_reg;
    logic       overlap_reg;

    logic [9*AW_-1:0]  ref_ax_reg, tst_ax_reg;
    logic [3*CW-1:0]   ref_ctr_reg;
    logic [3*LNW-1:0]  ref_len_reg, tst_len_reg;
    logic [3*DSW-1:0]  dist_reg;
    logic signed [SW-1:0]  s_reg [3];
    logic signed [PW-1:0]  prod_reg;
    logic signed [ACW-1:0] acc_reg;
    logic [LW-1:0] lhs_reg;
    logic [RW-1:0] rhs_reg;

    // operand selection for the shared multiplier
    logic [1:0] ai, bi, kax;
    logic [3:0] a_idx, b_idx, k_idx;
    logic signed [AW_-1:0] a_comp, b_comp, k_comp;
    logic signed [DSW-1:0] d_comp;
    logic [LNW-1:0] len_comp;
    logic [ACW-1:0] acc_abs;
    logic signed [SW-1:0] opa;
    logic signed [BW-1:0] opb;
    logic separated;
    logic last_axis;
    logic deliver;

    always_comb begin
        case (cnt_reg)
            3'd0: begin ai = 2'd1; bi = 2'd2; end
            3'd1: begin ai = 2'd2; bi = 2'd1; end
            3'd2: begin ai = 2'd2; bi = 2'd0; end
            3'd3: begin ai = 2'd0; bi = 2'd2; end
            3'd4: begin ai = 2'd0; bi = 2'd1; end
            3'd5: begin ai = 2'd1; bi = 2'd0; end
            default: begin ai = 2'd0; bi = 2'd0; end
        endcase
        kax     = (k_reg < 3'd3) ? k_reg[1:0] : 2'(k_reg - 3'd3);
        a_idx   = 4'(ia_reg) * 4'd3 + 4'(ai);
        b_idx   = 4'(jb_reg) * 4'd3 + 4'(bi);
        k_idx   = 4'(kax) * 4'd3 + 4'(cnt_reg[1:0]);
        a_comp  = ref_ax_reg[a_idx*AW_ +: AW_];
        b_comp  = tst_ax_reg[b_idx*AW_ +: AW_];
        k_comp  = (k_reg < 3'd3) ? ref_ax_reg[k_idx*AW_ +: AW_]
                                 : tst_ax_reg[k_idx*AW_ +: AW_];
        d_comp  = dist_reg[cnt_reg[1:0]*DSW +: DSW];
        len_comp = (k_reg < 3'd3) ? ref_len_reg[kax*LNW +: LNW]
                                  : tst_len_reg[kax*LNW +: LNW];
        acc_abs = acc_reg[ACW-1] ? ACW'(-acc_reg) : ACW'(acc_reg);
        case (state_reg)
            ST_CROSS: begin
                opa = SW'(a_comp);
                opb = BW'(b_comp);
            end
            ST_DDOT: begin
                opa = s_reg[cnt_reg[1:0]];
                opb = BW'(d_comp);
            end
            ST_SHDOT: begin
                opa = s_reg[cnt_reg[1:0]];
                opb = BW'(k_comp);
            end
            ST_SHLEN: begin
                opa = (cnt_reg == 3'd0) ? SW'(acc_abs[2*AW_-1:0])
                                        : SW'(acc_abs[DW-1:2*AW_]);
                opb = BW'(len_comp);
            end
            default: begin
                opa = '0;
                opb = '0;
            end
        endcase
        separated = XW'(lhs_reg) > XW'(rhs_reg);
        last_axis = (grp_reg == GRP_CRS) && (ia_reg == 2'd2) && (jb_reg == 2'd2);
        deliver   = (state_reg == ST_DONE) && (separated || result_reg == 1'b0 || last_axis)
                    && (!m_valid_reg || m_axis_tready);
    end

    // handshake outputs
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_W'(overlap_reg);

    // sequencer, datapath and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            grp_reg     <= GRP_REF;
            ia_reg      <= '0;
            jb_reg      <= '0;
            cnt_reg     <= '0;
            k_reg       <= '0;
            ph_reg      <= 1'b0;
            result_reg  <= 1'b1;
            m_valid_reg <= 1'b0;
            ref_ax_reg  <= '0;
            ref_ctr_reg <= '0;
            ref_len_reg <= '0;
        end else begin
            if (deliver) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
            prod_reg <= PW'(opa) * PW'(opb);
            case (state_reg)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        if (s_axis_tuser == CMD_STORE) begin
                            ref_ctr_reg <= s_axis_tdata[0 +: 3*CW];
                            ref_ax_reg  <= s_axis_tdata[OFF_AX +: 9*AW_];
                            ref_len_reg <= s_axis_tdata[OFF_LN +: 3*LNW];
                        end else begin
                            tst_ax_reg  <= s_axis_tdata[OFF_AX +: 9*AW_];
                            tst_len_reg <= s_axis_tdata[OFF_LN +: 3*LNW];
                            for (int i = 0; i < 3; i++) begin
                                dist_reg[i*DSW +: DSW] <=
                                    DSW'($signed(s_axis_tdata[i*CW +: CW]))
                                    - DSW'($signed(ref_ctr_reg[i*CW +: CW]));
                            end
                            grp_reg    <= GRP_REF;
                            ia_reg     <= '0;
                            jb_reg     <= '0;
                            result_reg <= 1'b1;
                            state_reg  <= ST_SETUP;
                        end
                    end
                end
                ST_SETUP: begin
                    cnt_reg <= '0;
                    ph_reg  <= 1'b0;
                    acc_reg <= '0;
                    if (grp_reg == GRP_CRS) begin
                        state_reg <= ST_CROSS;
                    end else begin
                        for (int i = 0; i < 3; i++) begin
                            s_reg[i] <= (grp_reg == GRP_REF)
                                ? SW'($signed(ref_ax_reg[(ia_reg*3+i)*AW_ +: AW_]))
                                : SW'($signed(tst_ax_reg[(ia_reg*3+i)*AW_ +: AW_]));
                        end
                        state_reg <= ST_DDOT;
                    end
                end
                // cross product of reference axis ia and test axis jb
                ST_CROSS: begin
                    ph_reg <= ~ph_reg;
                    if (ph_reg) begin
                        if (!cnt_reg[0]) begin
                            s_reg[cnt_reg[2:1]] <= prod_reg[SW-1:0];
                        end else begin
                            s_reg[cnt_reg[2:1]] <= s_reg[cnt_reg[2:1]] - prod_reg[SW-1:0];
                        end
                        if (cnt_reg == 3'd5) begin
                            cnt_reg   <= '0;
                            state_reg <= ST_DDOT;
                        end else begin
                            cnt_reg <= cnt_reg + 3'd1;
                        end
                    end
                end
                // projection of the centre difference
                ST_DDOT: begin
                    ph_reg <= ~ph_reg;
                    if (ph_reg) begin
                        acc_reg <= acc_reg + ACW'(prod_reg);
                        if (cnt_reg == 3'd2) begin
                            cnt_reg   <= '0;
                            state_reg <= ST_LHS;
                        end else begin
                            cnt_reg <= cnt_reg + 3'd1;
                        end
                    end
                end
                ST_LHS: begin
                    lhs_reg   <= LW'(acc_abs) << (AW_ - 1);
                    rhs_reg   <= '0;
                    acc_reg   <= '0;
                    k_reg     <= '0;
                    state_reg <= ST_SHDOT;
                end
                // axis against one box axis
                ST_SHDOT: begin
                    ph_reg <= ~ph_reg;
                    if (ph_reg) begin
                        acc_reg <= acc_reg + ACW'(prod_reg);
                        if (cnt_reg == 3'd2) begin
                            cnt_reg   <= '0;
                            state_reg <= ST_SHLEN;
                        end else begin
                            cnt_reg <= cnt_reg + 3'd1;
                        end
                    end
                end
                // magnitude times edge length, low and high slices
                ST_SHLEN: begin
                    ph_reg <= ~ph_reg;
                    if (ph_reg) begin
                        if (cnt_reg == 3'd0) begin
                            rhs_reg <= rhs_reg + RW'($unsigned(prod_reg));
                            cnt_reg <= 3'd1;
                        end else begin
                            rhs_reg <= rhs_reg + (RW'($unsigned(prod_reg)) << (2*AW_));
                            cnt_reg <= '0;
                            acc_reg <= '0;
                            if (k_reg == 3'd5) begin
                                state_reg <= ST_DONE;
                            end else begin
                                k_reg     <= k_reg + 3'd1;
                                state_reg <= ST_SHDOT;
                            end
                        end
                    end
                end
                // compare, step to the next axis, or deliver
                ST_DONE: begin
                    if (separated || result_reg == 1'b0 || last_axis) begin
                        result_reg <= ~separated && result_reg;
                        if (deliver) begin
                            overlap_reg <= ~separated && result_reg;
                            state_reg   <= ST_IDLE;
                        end
                        lhs_reg <= '0;
                        rhs_reg <= '0;
                    end else if (grp_reg == GRP_CRS) begin
                        state_reg <= ST_SETUP;
                        if (jb_reg == 2'd2) begin
                            jb_reg <= '0;
                            ia_reg <= ia_reg + 2'd1;
                        end else begin
                            jb_reg <= jb_reg + 2'd1;
                        end
                    end else begin
                        state_reg <= ST_SETUP;
                        if (ia_reg == 2'd2) begin
                            ia_reg  <= '0;
                            grp_reg <= grp_reg + 2'd1;
                        end else begin
                            ia_reg <= ia_reg + 2'd1;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ hw/rtl/obot_checker.sv @@
// port-level checks of the oriented box overlap test, bound to the top level
`timescale 1ns / 1ps
module obot_checker
    import obot_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             s_axis_tuser,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    // a test transfer makes the block busy
    a_test_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_TEST |=> !s_axis_tready)
        else $error("block still ready after a test transfer");

    // a store transfer produces no result
    a_store_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_STORE && !m_axis_tvalid
        |=> !m_axis_tvalid)
        else $error("result after a store transfer");

    // busy only follows a test transfer
    a_busy_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_axis_tready) |-> $past(s_axis_tvalid && s_axis_tuser == CMD_TEST))
        else $error("ready dropped without a test transfer");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind oriented_box_overlap_test obot_checker u_obot_checker (.*);
